FILE: sv/fcull_pkg.sv
// Shared types and constants for the frustum cull test block.
// Used by fcull_cfg, fcull_lane and frustum_cull_test_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

    // Number of plane slots held in the configuration registers.
    localparam int NUM_PLANES = 4;
    // Largest plane count that is honored; larger counts act as this value.
    localparam int MAX_PLANES = 4;

    // Field widths.
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int FRAC_W      = 14;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int DIST_W      = PROD_W + 4;
    localparam int PLANE_CNT_W = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_0     = CFG_IDX_W'(1);

    // Item kinds.
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // One plane as packed in its register: offset on top, normal below.
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } t_plane;

    // One test item.
    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [RADIUS_W-1:0] radius;
    } t_item;

endpackage

`default_nettype wire

FILE: sv/fcull_cfg.sv
// Configuration register file: plane count and the packed plane registers.
// Depends on fcull_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcull_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [fcull_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fcull_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output      logic                                 o_cfg_ready,
    output      logic [fcull_pkg::PLANE_CNT_W-1:0]    o_count,
    output      fcull_pkg::t_plane                    o_planes [fcull_pkg::NUM_PLANES]
);

    logic [fcull_pkg::PLANE_CNT_W-1:0] r_count;
    fcull_pkg::t_plane                 r_planes [fcull_pkg::NUM_PLANES];

    // Registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Plane count register; writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && (i_cfg_index == fcull_pkg::REG_PLANE_COUNT)) begin
            r_count <= i_cfg_data[fcull_pkg::PLANE_CNT_W-1:0];
        end
    end

    // Plane registers, one decode per slot.
    for (genvar p = 0; p < fcull_pkg::NUM_PLANES; p++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_planes[p] <= '0;
            end else if (i_cfg_valid &&
                         (i_cfg_index == fcull_pkg::CFG_IDX_W'(fcull_pkg::REG_PLANE_0 + p))) begin
                r_planes[p] <= i_cfg_data;
            end
        end
        assign o_planes[p] = r_planes[p];
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: sv/fcull_lane.sv
// One plane lane: corner selection, products, the signed distance sum and
// the outside compare, all combinational. Depends on fcull_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcull_lane (
    input  wire fcull_pkg::t_item  i_item,
    input  wire fcull_pkg::t_plane i_plane,
    output      logic              o_hit
);

    logic signed [fcull_pkg::COORD_W-1:0]  sel_x, sel_y, sel_z;
    logic signed [fcull_pkg::PROD_W-1:0]   prod_x, prod_y, prod_z;
    logic signed [fcull_pkg::DIST_W-1:0]   d_term, r_term, plane_sum, sphere_sum;

    // Sphere uses the center; a box takes min where the normal is negative.
    always_comb begin
        if (i_item.kind == fcull_pkg::KIND_SPHERE) begin
            sel_x = i_item.center_x;
            sel_y = i_item.center_y;
            sel_z = i_item.center_z;
        end else begin
            sel_x = i_plane.nx[fcull_pkg::COORD_W-1] ? i_item.min_x : i_item.max_x;
            sel_y = i_plane.ny[fcull_pkg::COORD_W-1] ? i_item.min_y : i_item.max_y;
            sel_z = i_plane.nz[fcull_pkg::COORD_W-1] ? i_item.min_z : i_item.max_z;
        end
        prod_x = sel_x * i_plane.nx;
        prod_y = sel_y * i_plane.ny;
        prod_z = sel_z * i_plane.nz;
    end

    // Distance in units of one fraction step, then the per-kind compare.
    always_comb begin
        d_term = {{(fcull_pkg::DIST_W - fcull_pkg::COORD_W - fcull_pkg::FRAC_W)
                   {i_plane.d[fcull_pkg::COORD_W-1]}},
                  i_plane.d, {fcull_pkg::FRAC_W{1'b0}}};
        r_term = {{(fcull_pkg::DIST_W - fcull_pkg::RADIUS_W - fcull_pkg::FRAC_W){1'b0}},
                  i_item.radius, {fcull_pkg::FRAC_W{1'b0}}};
        plane_sum = fcull_pkg::DIST_W'(prod_x) + fcull_pkg::DIST_W'(prod_y)
                  + fcull_pkg::DIST_W'(prod_z) + d_term;
        sphere_sum = plane_sum + r_term;
        if (i_item.kind == fcull_pkg::KIND_SPHERE) begin
            o_hit = sphere_sum[fcull_pkg::DIST_W-1];
        end else begin
            o_hit = plane_sum[fcull_pkg::DIST_W-1] || (plane_sum == '0);
        end
    end

endmodule

`default_nettype wire

FILE: sv/frustum_cull_test_top.sv
// Frustum cull test: one object against up to four clipping planes.
// Path: an accepted item passes the input register, then the result register,
// which drives the result strobe o_done and the outside flag o_outside.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) clears the pipeline valids, outside flag, plane count
// and plane registers. Depends on fcull_pkg, fcull_cfg and fcull_lane.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output      logic                                 busy,
    input  wire logic                                 i_kind,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_min_x,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_min_y,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_min_z,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_max_x,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_max_y,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_max_z,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_center_x,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_center_y,
    input  wire logic signed [fcull_pkg::COORD_W-1:0] i_center_z,
    input  wire logic        [fcull_pkg::RADIUS_W-1:0] i_radius,
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [fcull_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fcull_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output      logic                                 o_done,
    output      logic                                 o_outside
);

    logic                              accept;
    fcull_pkg::t_item                  r_item;
    logic                              r_vld0;
    logic                              r_done, r_outside;
    logic                              n_outside;
    logic [fcull_pkg::PLANE_CNT_W-1:0] count;
    fcull_pkg::t_plane                 planes [fcull_pkg::NUM_PLANES];
    logic [fcull_pkg::NUM_PLANES-1:0]  hit, active;

    // The pipeline takes an item every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    fcull_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_count     (count),
        .o_planes    (planes)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind     <= i_kind;
            r_item.min_x    <= i_min_x;
            r_item.min_y    <= i_min_y;
            r_item.min_z    <= i_min_z;
            r_item.max_x    <= i_max_x;
            r_item.max_y    <= i_max_y;
            r_item.max_z    <= i_max_z;
            r_item.center_x <= i_center_x;
            r_item.center_y <= i_center_y;
            r_item.center_z <= i_center_z;
            r_item.radius   <= i_radius;
        end
    end

    // One lane per plane slot; a slot is active below the clamped count.
    for (genvar p = 0; p < fcull_pkg::NUM_PLANES; p++) begin : g_lane
        fcull_lane u_lane (
            .i_item  (r_item),
            .i_plane (planes[p]),
            .o_hit   (hit[p])
        );
        assign active[p] = (count > fcull_pkg::PLANE_CNT_W'(p)) && (p < fcull_pkg::MAX_PLANES);
    end

    assign n_outside = |(hit & active);

    // Valid pipeline and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld0 <= accept;
            r_done <= r_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outside <= 1'b0;
        end else begin
            r_outside <= r_vld0 && n_outside;
        end
    end

    assign o_done    = r_done;
    assign o_outside = r_outside;

endmodule

`default_nettype wire

FILE: sv/fcull_checker.sv
// Port-level checks for the frustum cull test top level, with its bind.
// Depends on frustum_cull_test_top.
`timescale 1ns / 1ps
`default_nettype none

module fcull_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_outside,
    input wire logic o_cfg_ready
);

    // Every accepted item yields its result strobe o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing two cycles after a transfer");

    // No result appears without a matching earlier transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching transfer");

    // The outside flag is quiet between results.
    a_quiet: assert property (@(posedge i_clk)
        !o_done |-> !o_outside)
        else $error("outside flag high without a result strobe");

    // Right after reset no result is shown.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

    // The configuration channel takes a write in every cycle out of reset.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind frustum_cull_test_top fcull_checker u_fcull_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_outside   (o_outside),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
